/* sv/bmseq_pkg.sv */
package bmseq_pkg;

    // melody length and table sizes
    localparam int NOTE_COUNT = 102;
    localparam int NOTE_W     = 7;
    localparam int HALF_W     = 10;
    localparam int DUR_W      = 9;
    localparam int ACC_W      = 16;
    localparam int ELAPSED_W  = 15;
    localparam int PCT_W      = 7;

    // configuration register indexes
    localparam logic CFG_GATE_PERCENT = 1'b0;
    localparam logic CFG_TICK_MS      = 1'b1;

    localparam logic [PCT_W-1:0] GATE_RESET = 7'd90;
    localparam logic [PCT_W-1:0] TICK_RESET = 7'd10;
    localparam logic [ACC_W-1:0] PCT_SCALE  = 16'd100;

    // action codes
    localparam logic [1:0] ACT_ADVANCE = 2'd0;
    localparam logic [1:0] ACT_START   = 2'd1;
    localparam logic [1:0] ACT_STOP    = 2'd2;

    // half periods in microseconds
    localparam logic [HALF_W-1:0] HP_REST = 10'd0;
    localparam logic [HALF_W-1:0] HP_E6   = 10'd379;
    localparam logic [HALF_W-1:0] HP_G6   = 10'd319;
    localparam logic [HALF_W-1:0] HP_GS6  = 10'd301;
    localparam logic [HALF_W-1:0] HP_A6   = 10'd284;
    localparam logic [HALF_W-1:0] HP_AS6  = 10'd268;
    localparam logic [HALF_W-1:0] HP_B6   = 10'd253;
    localparam logic [HALF_W-1:0] HP_C7   = 10'd239;
    localparam logic [HALF_W-1:0] HP_D7   = 10'd213;
    localparam logic [HALF_W-1:0] HP_DS7  = 10'd201;
    localparam logic [HALF_W-1:0] HP_E7   = 10'd190;
    localparam logic [HALF_W-1:0] HP_F7   = 10'd179;
    localparam logic [HALF_W-1:0] HP_FS7  = 10'd169;
    localparam logic [HALF_W-1:0] HP_G7   = 10'd159;
    localparam logic [HALF_W-1:0] HP_A7   = 10'd142;

    // note lengths in milliseconds
    localparam logic [DUR_W-1:0] D8  = 9'd125;
    localparam logic [DUR_W-1:0] D4  = 9'd250;
    localparam logic [DUR_W-1:0] D4D = 9'd375;
    localparam logic [DUR_W-1:0] D2  = 9'd500;

    typedef struct packed {
        logic [HALF_W-1:0] half;
        logic [DUR_W-1:0]  dur;
    } t_note;

    typedef struct packed {
        logic [1:0] action;
        logic [7:0] elapsed_ticks;
    } t_in;

    typedef struct packed {
        logic              buzzer_on;
        logic [HALF_W-1:0] tone_half_period;
        logic              tone_reload;
        logic              is_playing;
        logic [NOTE_W-1:0] note_position;
    } t_out;

    typedef struct packed {
        logic             ge;
        logic [ACC_W-1:0] diff;
    } t_alu_res;

    localparam t_note MELODY [0:NOTE_COUNT-1] = '{
        '{HP_E7, D8}, '{HP_E7, D8}, '{HP_REST, D8}, '{HP_E7, D8}, '{HP_REST, D8},
        '{HP_C7, D8}, '{HP_E7, D4},
        '{HP_G7, D2}, '{HP_REST, D4}, '{HP_G6, D4},
        '{HP_C7, D4D}, '{HP_G6, D8}, '{HP_REST, D4}, '{HP_E6, D4},
        '{HP_A6, D4}, '{HP_B6, D4}, '{HP_AS6, D8}, '{HP_A6, D8}, '{HP_G6, D4},
        '{HP_E7, D8}, '{HP_G7, D8}, '{HP_A7, D4}, '{HP_F7, D8}, '{HP_G7, D8},
        '{HP_REST, D4},
        '{HP_E7, D4}, '{HP_C7, D8}, '{HP_D7, D8}, '{HP_B6, D4}, '{HP_REST, D4},
        '{HP_C7, D4D}, '{HP_G6, D8}, '{HP_REST, D4}, '{HP_E6, D4},
        '{HP_A6, D4}, '{HP_B6, D4}, '{HP_AS6, D8}, '{HP_A6, D8}, '{HP_G6, D4},
        '{HP_E7, D8}, '{HP_G7, D8}, '{HP_A7, D4}, '{HP_F7, D8}, '{HP_G7, D8},
        '{HP_REST, D4},
        '{HP_E7, D4}, '{HP_C7, D8}, '{HP_D7, D8}, '{HP_B6, D2},
        '{HP_REST, D8}, '{HP_G7, D8}, '{HP_FS7, D8}, '{HP_F7, D8}, '{HP_DS7, D4},
        '{HP_E7, D4},
        '{HP_REST, D8}, '{HP_GS6, D8}, '{HP_A6, D8}, '{HP_C7, D8}, '{HP_REST, D8},
        '{HP_A6, D8}, '{HP_C7, D8}, '{HP_D7, D8},
        '{HP_REST, D8}, '{HP_DS7, D8}, '{HP_D7, D8}, '{HP_C7, D8}, '{HP_REST, D4},
        '{HP_G6, D4},
        '{HP_C7, D8}, '{HP_C7, D8}, '{HP_C7, D4}, '{HP_REST, D8}, '{HP_C7, D8},
        '{HP_D7, D4},
        '{HP_E7, D4}, '{HP_C7, D4}, '{HP_A6, D4}, '{HP_G6, D4},
        '{HP_E7, D8}, '{HP_E7, D8}, '{HP_REST, D8}, '{HP_E7, D8}, '{HP_REST, D8},
        '{HP_C7, D8}, '{HP_E7, D4},
        '{HP_G7, D2}, '{HP_REST, D4}, '{HP_G6, D4},
        '{HP_C7, D4}, '{HP_G6, D4}, '{HP_E6, D4}, '{HP_A6, D4},
        '{HP_B6, D4}, '{HP_AS6, D8}, '{HP_A6, D8}, '{HP_G6, D4}, '{HP_E7, D4},
        '{HP_C7, D8}, '{HP_D7, D8}, '{HP_B6, D4}, '{HP_C7, D2}
    };

    // melody table lookup, D8 rest past the end
    function automatic t_note note_at(input logic [NOTE_W-1:0] idx);
        t_note res;
        res = '{HP_REST, D8};
        if (int'(idx) < NOTE_COUNT) begin
            res = MELODY[idx];
        end
        return res;
    endfunction

endpackage

/* sv/bmseq_alu.sv */
module bmseq_alu (
    input  logic [bmseq_pkg::ACC_W-1:0] i_a,
    input  logic [bmseq_pkg::ACC_W-1:0] i_b,
    output bmseq_pkg::t_alu_res         o_res
);

    logic [bmseq_pkg::ACC_W:0] diff_ext;

    // one subtract gives both the difference and a >= b
    assign diff_ext   = {1'b0, i_a} - {1'b0, i_b};
    assign o_res.ge   = ~diff_ext[bmseq_pkg::ACC_W];
    assign o_res.diff = diff_ext[bmseq_pkg::ACC_W-1:0];

endmodule

/* sv/buzzer_melody_sequencer.sv */
// channel   valid         stall         payload
// input     i_in_valid    o_in_stall    i_in_data  (t_in)
// output    o_out_valid   i_out_stall   o_out_data (t_out)
// config    i_cfg_we      -             i_cfg_index, i_cfg_data
//
// start, stop, unused codes and advances that change nothing go from accept to
// S_DONE and then to the result register.
// advance: S_MUL, S_STEP (n notes stepped, n <= 263), S_GATE_MUL, S_GATE_CMP,
// S_DONE; one subtractor serves the per-note duration step and the gate compare.
// input stalls while an item is at work; a finished result waits in the
// sequencer when the output register is full and stalled.
// reset (synchronous, active low) stops playback and restores register defaults.
module buzzer_melody_sequencer (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  bmseq_pkg::t_in                  i_in_data,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output bmseq_pkg::t_out                 o_out_data,
    input  logic                            i_cfg_we,
    input  logic                            i_cfg_index,
    input  logic [bmseq_pkg::PCT_W-1:0]     i_cfg_data
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_STEP,
        S_GATE_MUL,
        S_GATE_CMP,
        S_DONE
    } t_state;

    t_state                              r_state, n_state;
    logic [bmseq_pkg::PCT_W-1:0]         r_gate, n_gate;
    logic [bmseq_pkg::PCT_W-1:0]         r_tick, n_tick;
    logic                                r_playing, n_playing;
    logic                                r_gate_closed, n_gate_closed;
    logic [bmseq_pkg::NOTE_W-1:0]        r_note, n_note;
    logic [bmseq_pkg::ELAPSED_W-1:0]     r_elapsed, n_elapsed;
    logic [bmseq_pkg::ACC_W-1:0]         r_acc, n_acc;
    logic [bmseq_pkg::ACC_W-1:0]         r_gprod, n_gprod;
    logic [7:0]                          r_ticks, n_ticks;
    logic                                r_reload, n_reload;
    logic                                r_out_valid, n_out_valid;
    bmseq_pkg::t_out                     r_out, n_out;

    bmseq_pkg::t_note                    cur_note;
    bmseq_pkg::t_note                    nxt_note;
    logic [bmseq_pkg::NOTE_W-1:0]        nxt_idx;
    logic [bmseq_pkg::ACC_W-1:0]         alu_a, alu_b;
    bmseq_pkg::t_alu_res                 alu_res;
    logic                                out_free;

    // melody lookups for current and following note
    assign cur_note = bmseq_pkg::note_at(r_note);
    assign nxt_idx  = (r_note == bmseq_pkg::NOTE_W'(bmseq_pkg::NOTE_COUNT - 1))
                      ? '0 : r_note + 1'b1;
    assign nxt_note = bmseq_pkg::note_at(nxt_idx);

    // shared subtractor: duration step, then gate compare
    always_comb begin
        if (r_state == S_GATE_CMP) begin
            alu_a = r_gprod;
            alu_b = r_acc;
        end else begin
            alu_a = r_acc;
            alu_b = {{(bmseq_pkg::ACC_W - bmseq_pkg::DUR_W){1'b0}}, cur_note.dur};
        end
    end

    bmseq_alu u_alu (
        .i_a   (alu_a),
        .i_b   (alu_b),
        .o_res (alu_res)
    );

    assign out_free    = ~r_out_valid | ~i_out_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // sequencer next state
    always_comb begin
        n_state       = r_state;
        n_gate        = r_gate;
        n_tick        = r_tick;
        n_playing     = r_playing;
        n_gate_closed = r_gate_closed;
        n_note        = r_note;
        n_elapsed     = r_elapsed;
        n_acc         = r_acc;
        n_gprod       = r_gprod;
        n_ticks       = r_ticks;
        n_reload      = r_reload;
        n_out_valid   = r_out_valid & i_out_stall;
        n_out         = r_out;

        // configuration writes
        if (i_cfg_we) begin
            if (i_cfg_index == bmseq_pkg::CFG_GATE_PERCENT) begin
                n_gate = i_cfg_data;
            end else begin
                n_tick = i_cfg_data;
            end
        end

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_reload = 1'b0;
                    n_ticks  = i_in_data.elapsed_ticks;
                    n_state  = S_DONE;
                    case (i_in_data.action)
                        bmseq_pkg::ACT_START: begin
                            n_note        = '0;
                            n_elapsed     = '0;
                            n_playing     = 1'b1;
                            n_gate_closed = (bmseq_pkg::note_at('0).half
                                             == bmseq_pkg::HP_REST);
                            n_reload      = 1'b1;
                        end
                        bmseq_pkg::ACT_STOP: begin
                            n_playing     = 1'b0;
                            n_gate_closed = 1'b1;
                            n_note        = '0;
                            n_elapsed     = '0;
                        end
                        bmseq_pkg::ACT_ADVANCE: begin
                            if (r_playing && (i_in_data.elapsed_ticks != 8'd0)) begin
                                n_state = S_MUL;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            // accumulate elapsed time
            S_MUL: begin
                n_acc   = {1'b0, r_elapsed}
                          + ({{(bmseq_pkg::ACC_W - 8){1'b0}}, r_ticks}
                             * {{(bmseq_pkg::ACC_W - bmseq_pkg::PCT_W){1'b0}}, r_tick});
                n_state = S_STEP;
            end
            // one note per cycle while its duration has passed
            S_STEP: begin
                if (alu_res.ge) begin
                    n_acc         = alu_res.diff;
                    n_note        = nxt_idx;
                    n_gate_closed = (nxt_note.half == bmseq_pkg::HP_REST);
                    n_reload      = 1'b1;
                end else begin
                    n_elapsed = r_acc[bmseq_pkg::ELAPSED_W-1:0];
                    n_state   = S_GATE_MUL;
                end
            end
            // gate threshold: cut when 100 * (acc + 1) > dur * gate
            S_GATE_MUL: begin
                n_gprod = {{(bmseq_pkg::ACC_W - bmseq_pkg::DUR_W){1'b0}}, cur_note.dur}
                          * {{(bmseq_pkg::ACC_W - bmseq_pkg::PCT_W){1'b0}}, r_gate};
                n_acc   = bmseq_pkg::ACC_W'((r_acc[bmseq_pkg::DUR_W-1:0] + 10'd1)
                                            * bmseq_pkg::PCT_SCALE);
                n_state = S_GATE_CMP;
            end
            S_GATE_CMP: begin
                if ((cur_note.half != bmseq_pkg::HP_REST) && !r_gate_closed
                    && !alu_res.ge) begin
                    n_gate_closed = 1'b1;
                end
                n_state = S_DONE;
            end
            // hand the result to the output register
            S_DONE: begin
                if (out_free) begin
                    n_out_valid            = 1'b1;
                    n_out.buzzer_on        = ~r_gate_closed;
                    n_out.tone_half_period = r_playing ? cur_note.half : '0;
                    n_out.tone_reload      = r_reload;
                    n_out.is_playing       = r_playing;
                    n_out.note_position    = r_note;
                    n_state                = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_gate        <= bmseq_pkg::GATE_RESET;
            r_tick        <= bmseq_pkg::TICK_RESET;
            r_playing     <= 1'b0;
            r_gate_closed <= 1'b1;
            r_note        <= '0;
            r_elapsed     <= '0;
            r_reload      <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_gate        <= n_gate;
            r_tick        <= n_tick;
            r_playing     <= n_playing;
            r_gate_closed <= n_gate_closed;
            r_note        <= n_note;
            r_elapsed     <= n_elapsed;
            r_reload      <= n_reload;
            r_out_valid   <= n_out_valid;
        end
        r_acc   <= n_acc;
        r_gprod <= n_gprod;
        r_ticks <= n_ticks;
        r_out   <= n_out;
    end

endmodule
